// ===== sv/lch_pkg.sv =====
// Shared constants and byte helpers for the line compare hash unit.
`default_nettype none
package lch_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned HashWidth  = 32;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 1;

   typedef logic [CharWidth-1:0] char_type;
   typedef logic [HashWidth-1:0] hash_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_IGNORE_WS      = 3'd0,
      CSR_IGNORE_CASE    = 3'd1,
      CSR_COMPRESS       = 3'd2,
      CSR_SUPPRESS_CR    = 3'd3,
      CSR_SUPPRESS_LEAD  = 3'd4,
      CSR_SUPPRESS_TRAIL = 3'd5
   } csr_idx_type;

   localparam char_type CharTab   = 8'h09;
   localparam char_type CharVt    = 8'h0B;
   localparam char_type CharFf    = 8'h0C;
   localparam char_type CharCr    = 8'h0D;
   localparam char_type CharSpace = 8'h20;
   localparam char_type FoldLow   = 8'h40;
   localparam char_type FoldHigh  = 8'h5F;
   localparam char_type FoldAdd   = 8'h20;

   localparam hash_type HashSeed = 32'd1;

   typedef struct packed {
      logic ignore_ws;
      logic ignore_case;
      logic compress;
      logic suppress_cr;
      logic suppress_lead;
      logic suppress_trail;
   } mode_type;

   function automatic logic is_blank(input char_type c);
      is_blank = (c == CharTab) || (c == CharVt) || (c == CharFf) || (c == CharSpace);
   endfunction

   function automatic char_type fold(input char_type c, input logic en);
      if (en && (c >= FoldLow) && (c <= FoldHigh)) begin
         fold = c + FoldAdd;
      end else begin
         fold = c;
      end
   endfunction

   // sum * 127 + c, mod 2^32, as shift and subtract
   function automatic hash_type mix(input hash_type sum, input char_type c);
      mix = (sum << 7) - sum + hash_type'(c);
   endfunction

endpackage
`default_nettype wire

// ===== sv/line_compare_hash_unit.sv =====
// Line compare hash unit: streaming base-127 line hash with blank and case modes.
// A line's hash is loaded into the result register as its last byte leaves the request
// register. Throughput: one byte per cycle unless a last byte waits on the result slot;
// request and result registers part the two sides, with one pass of hash logic between.
// Reset: synchronous, active high; clears modes to 0, sums to 1, both channels empty.
`default_nettype none
module line_compare_hash_unit
   import lch_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request: tdata = {char_byte[7:0]}, tuser = {empty_line}
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   input  wire logic [CharWidth-1:0]    req_tdata,
   input  wire logic                    req_tlast,
   input  wire logic                    req_tuser,
   // result: tdata = {line_hash[31:0]}
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   output      logic [HashWidth-1:0]    rsp_tdata,
   // configuration
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   mode_type mode_ff;

   logic     req_valid_ff;
   char_type req_char_ff;
   logic     req_last_ff;
   logic     req_empty_ff;

   hash_type run_sum_ff, run_sum_in;
   hash_type kept_sum_ff, kept_sum_in;
   logic     pend_ff, pend_in;
   logic     start_ff, start_in;

   logic     rsp_valid_ff;
   hash_type rsp_hash_ff;

   logic     advance;
   logic     drop_cr;
   logic     blank;
   char_type folded;
   hash_type base_sum;
   hash_type upd_run;
   hash_type upd_kept;
   logic     upd_pend;
   logic     upd_start;
   hash_type line_hash;

   // a non-last byte always moves on; a last byte needs the result slot
   assign advance    = req_valid_ff && (!req_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_hash_ff;

   assign drop_cr  = mode_ff.suppress_cr && req_last_ff && (req_char_ff == CharCr);
   assign blank    = is_blank(req_char_ff);
   assign folded   = fold(req_char_ff, mode_ff.ignore_case);
   assign base_sum = (mode_ff.compress && pend_ff) ? mix(run_sum_ff, CharSpace) : run_sum_ff;

   always_comb begin
      upd_run   = run_sum_ff;
      upd_kept  = kept_sum_ff;
      upd_pend  = pend_ff;
      upd_start = start_ff;
      if (!req_empty_ff && !drop_cr) begin
         if (mode_ff.ignore_ws) begin
            if (!(blank || (req_char_ff == CharCr))) begin
               upd_run  = mix(run_sum_ff, folded);
               upd_kept = upd_run;
            end
         end else if (blank) begin
            if (mode_ff.suppress_lead && start_ff) begin
               upd_run = run_sum_ff;
            end else if (mode_ff.compress) begin
               upd_pend = 1'b1;
            end else begin
               upd_run = mix(run_sum_ff, req_char_ff);
            end
         end else begin
            upd_run   = mix(base_sum, folded);
            upd_kept  = upd_run;
            upd_pend  = 1'b0;
            upd_start = 1'b0;
         end
      end
   end

   assign line_hash = (mode_ff.suppress_trail && !mode_ff.ignore_ws) ? upd_kept : upd_run;

   always_comb begin
      run_sum_in  = run_sum_ff;
      kept_sum_in = kept_sum_ff;
      pend_in     = pend_ff;
      start_in    = start_ff;
      if (advance) begin
         if (req_last_ff) begin
            run_sum_in  = HashSeed;
            kept_sum_in = HashSeed;
            pend_in     = 1'b0;
            start_in    = 1'b1;
         end else begin
            run_sum_in  = upd_run;
            kept_sum_in = upd_kept;
            pend_in     = upd_pend;
            start_in    = upd_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_IGNORE_WS:      mode_ff.ignore_ws      <= csr_wdata[0];
            CSR_IGNORE_CASE:    mode_ff.ignore_case    <= csr_wdata[0];
            CSR_COMPRESS:       mode_ff.compress       <= csr_wdata[0];
            CSR_SUPPRESS_CR:    mode_ff.suppress_cr    <= csr_wdata[0];
            CSR_SUPPRESS_LEAD:  mode_ff.suppress_lead  <= csr_wdata[0];
            CSR_SUPPRESS_TRAIL: mode_ff.suppress_trail <= csr_wdata[0];
            default:            mode_ff <= mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_sum_ff   <= HashSeed;
         kept_sum_ff  <= HashSeed;
         pend_ff      <= 1'b0;
         start_ff     <= 1'b1;
      end else begin
         run_sum_ff  <= run_sum_in;
         kept_sum_ff <= kept_sum_in;
         pend_ff     <= pend_in;
         start_ff    <= start_in;
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance && req_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_char_ff  <= req_tdata;
         req_last_ff  <= req_tlast;
         req_empty_ff <= req_tuser;
      end
      if (advance && req_last_ff) begin
         rsp_hash_ff <= line_hash;
      end
   end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for line_compare_hash_unit: random lines, mode sweeps, scored hashes.
`timescale 1ns / 1ps
module tb_top;
   import lch_pkg::*;

   localparam hash_type HashBase = 32'd127;
   localparam int DrainCycles = 6;
   localparam int HoldCycles = 300;

   typedef struct {
      char_type ch;
      logic last;
      logic empty;
   } line_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [CharWidth-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [HashWidth-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   line_compare_hash_unit uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),     // char_byte[7:0]
      .req_tlast(req_tlast),
      .req_tuser(req_tuser),     // empty_line
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),     // line_hash[31:0]
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   line_req_type request_q[$];
   hash_type line_hash_q[$];

   // hash predictor state
   mode_type mode = '0;
   hash_type run_hash = HashSeed;
   hash_type kept_hash = HashSeed;
   logic blank_waiting = 1'b0;
   logic line_fresh = 1'b1;

   int req_count = 0;
   int hash_count = 0;
   int errors = 0;
   int mode_count = 0;
   logic req_fire = 1'b0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   wire calm = (req_count >= 900) && (req_count < 1100);

   function automatic char_type fold_case(input char_type ch);
      if (mode.ignore_case && ch >= FoldLow && ch <= FoldHigh) begin
         return ch + FoldAdd;
      end
      return ch;
   endfunction

   task automatic predict_line_hash(input char_type ch, input logic last, input logic empty);
      logic blank_ch;
      logic is_cr;
      blank_ch = (ch == CharTab) || (ch == CharVt) || (ch == CharFf) || (ch == CharSpace);
      is_cr = (ch == CharCr);
      if (!empty) begin
         if (mode.suppress_cr && last && is_cr) begin
            // final CR dropped
         end else if (mode.ignore_ws) begin
            if (!(blank_ch || is_cr)) begin
               run_hash = run_hash * HashBase + hash_type'(fold_case(ch));
               kept_hash = run_hash;
            end
         end else if (blank_ch) begin
            if (mode.suppress_lead && line_fresh) begin
               // leading blank skipped
            end else if (mode.compress) begin
               blank_waiting = 1'b1;
            end else begin
               run_hash = run_hash * HashBase + hash_type'(ch);
            end
         end else begin
            if (mode.compress && blank_waiting) begin
               run_hash = run_hash * HashBase + hash_type'(CharSpace);
            end
            blank_waiting = 1'b0;
            run_hash = run_hash * HashBase + hash_type'(fold_case(ch));
            kept_hash = run_hash;
            line_fresh = 1'b0;
         end
      end
      if (last) begin
         line_hash_q.push_back((mode.suppress_trail && !mode.ignore_ws) ? kept_hash : run_hash);
         run_hash = HashSeed;
         kept_hash = HashSeed;
         blank_waiting = 1'b0;
         line_fresh = 1'b1;
      end
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      line_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
            nxt = request_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= nxt.ch;
            req_tlast <= nxt.last;
            req_tuser <= nxt.empty;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_count >= 500) begin
         hold_done <= 1'b1;
         hold_left <= HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 26);
      end
   end

   // acceptance, prediction and scoring
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            predict_line_hash(req_tdata, req_tlast, req_tuser);
            req_count = req_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            hash_count = hash_count + 1;
            if (line_hash_q.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10) begin
                  $display("%0t: unexpected line_hash %h", $realtime, rsp_tdata);
               end
            end else begin
               if (rsp_tdata !== line_hash_q[0]) begin
                  errors = errors + 1;
                  if (errors <= 10) begin
                     $display("%0t: line_hash mismatch: expected %h, got %h",
                              $realtime, line_hash_q[0], rsp_tdata);
                  end
               end
               void'(line_hash_q.pop_front());
            end
         end
      end
   end

   function automatic void push_request(input char_type ch, input logic last,
                                        input logic empty);
      line_req_type r;
      r.ch = ch;
      r.last = last;
      r.empty = empty;
      request_q.push_back(r);
   endfunction

   function automatic char_type pick_blank();
      case ($urandom_range(0, 3))
         0: return CharTab;
         1: return CharVt;
         2: return CharFf;
         default: return CharSpace;
      endcase
   endfunction

   function automatic char_type pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 28) return pick_blank();
      if (r < 36) return CharCr;
      if (r < 60) return char_type'($urandom_range(8'h3E, 8'h61));
      return char_type'($urandom_range(0, 255));
   endfunction

   // one line: optional leading blanks, body, optional trailing blanks and optional final CR, or a noise line
   task automatic queue_line(output int n_chars);
      char_type body[$];
      int lead, core, tail;
      logic end_empty;
      if ($urandom_range(0, 99) < 20) begin
         // noise line: raw bytes of any value
         core = $urandom_range(0, 10);
         for (int i = 0; i < core; i++) body.push_back(char_type'($urandom_range(0, 255)));
      end else begin
         lead = ($urandom_range(0, 99) < 40) ? $urandom_range(1, 3) : 0;
         core = ($urandom_range(0, 99) < 3) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         tail = ($urandom_range(0, 99) < 40) ? $urandom_range(1, 3) : 0;
         for (int i = 0; i < lead; i++) body.push_back(pick_blank());
         for (int i = 0; i < core; i++) body.push_back(pick_char());
         for (int i = 0; i < tail; i++) body.push_back(pick_blank());
         if ($urandom_range(0, 99) < 20) body.push_back(CharCr);
      end
      end_empty = (body.size() == 0) || ($urandom_range(0, 99) < 15);
      for (int i = 0; i < body.size(); i++) begin
         if ($urandom_range(0, 99) < 5) begin
            push_request(char_type'($urandom_range(0, 255)), 1'b0, 1'b1);
         end
         push_request(body[i], (i == body.size() - 1) && !end_empty, 1'b0);
      end
      if (end_empty) push_request(char_type'($urandom_range(0, 255)), 1'b1, 1'b1);
      n_chars = body.size();
   endtask

   task automatic wait_drained();
      while (request_q.size() != 0 || req_tvalid || line_hash_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_IGNORE_WS:      mode.ignore_ws = v;
         CSR_IGNORE_CASE:    mode.ignore_case = v;
         CSR_COMPRESS:       mode.compress = v;
         CSR_SUPPRESS_CR:    mode.suppress_cr = v;
         CSR_SUPPRESS_LEAD:  mode.suppress_lead = v;
         CSR_SUPPRESS_TRAIL: mode.suppress_trail = v;
         default: ;
      endcase
   endtask

   task automatic write_mode(input mode_type m);
      write_csr(CSR_IGNORE_WS, m.ignore_ws);
      write_csr(CSR_IGNORE_CASE, m.ignore_case);
      write_csr(CSR_COMPRESS, m.compress);
      write_csr(CSR_SUPPRESS_CR, m.suppress_cr);
      write_csr(CSR_SUPPRESS_LEAD, m.suppress_lead);
      write_csr(CSR_SUPPRESS_TRAIL, m.suppress_trail);
      @(negedge clock);
      csr_we <= 1'b0;
      mode_count = mode_count + 1;
   endtask

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      mode_type m;
      int n, chars;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every mode but ignore_ws
      m = '1;
      m.ignore_ws = 1'b0;
      write_mode(m);
      push_request(8'h5A, 1'b1, 1'b1);                  // lone empty line
      push_request(CharSpace, 1'b0, 1'b0);              // leading blanks
      push_request(CharTab, 1'b0, 1'b0);
      push_request(8'h41, 1'b0, 1'b0);                  // case fold edges
      push_request(FoldLow, 1'b0, 1'b0);
      push_request(FoldHigh, 1'b0, 1'b0);
      push_request(8'h3F, 1'b0, 1'b0);
      push_request(8'h60, 1'b0, 1'b0);
      push_request(CharCr, 1'b0, 1'b0);                 // inner CR is ordinary
      push_request(CharSpace, 1'b0, 1'b0);              // inner run -> one space
      push_request(CharVt, 1'b0, 1'b0);
      push_request(8'h7A, 1'b0, 1'b0);
      push_request(CharFf, 1'b0, 1'b0);                 // trailing blank
      push_request(8'hA5, 1'b0, 1'b1);                  // empty, not last
      push_request(CharCr, 1'b1, 1'b0);                 // final CR dropped
      push_request(8'h00, 1'b0, 1'b0);
      push_request(8'hFF, 1'b0, 1'b0);
      push_request(8'h00, 1'b1, 1'b1);                  // empty item ends line
      wait_drained();

      write_mode('1);
      push_request(CharSpace, 1'b0, 1'b0);
      push_request(CharCr, 1'b0, 1'b0);
      push_request(8'h51, 1'b0, 1'b0);
      push_request(CharTab, 1'b0, 1'b0);
      push_request(CharVt, 1'b1, 1'b0);
      wait_drained();

      // random lines under a sweep of modes, extremes first
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 0) m = '0;
         else if (ph == 1) m = '1;
         else m = mode_type'($urandom_range(0, 63));
         write_mode(m);
         n = 0;
         while (n < 115) begin
            queue_line(chars);
            n = n + chars;
         end
         wait_drained();
      end

      if (line_hash_q.size() != 0) errors = errors + line_hash_q.size();
      $display("Requests accepted: %0d, line hashes checked: %0d, mode settings: %0d",
               req_count, hash_count, mode_count);
      $display("Mismatches: %0d", errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
